// ===== design/bia_pkg.sv =====
// shared types, codes and constants of the bitmap index allocator
package bia_pkg;

    // field and register widths
    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 10;
    localparam int COUNT_W  = 11;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 11;

    // map storage is organised in words of this many bits
    localparam int WORD_W     = 32;
    localparam int WORD_SHIFT = 5;

    // default map size and counter ceiling of the counter register
    localparam int MAX_SLOTS_DEFAULT = 1024;
    localparam int COUNT_HW_MAX      = 2047;

    // register reset values
    localparam logic [COUNT_W-1:0] SLOTS_RESET = 11'd1024;
    localparam logic [INDEX_W-1:0] ROOT_RESET  = 10'd1;

    // register indices on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_ROOT_IDX = 1'b1;

    // action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOCATE  = 2'd0,
        ACT_RELEASE   = 2'd1,
        ACT_MARK_USED = 2'd2,
        ACT_SET_COUNT = 2'd3
    } action_t;

    // controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic clear_write;
        logic load;
        logic step;
        logic finish;
    } ctrl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic clear_last;
        logic need_more;
    } dp_status_t;

endpackage

// ===== design/bia_ctrl.sv =====
// controller state machine of the bitmap index allocator
module bia_ctrl
    import bia_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output logic       busy,
    output logic       done
);

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    // state and strobe registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_write = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.need_more)
                begin
                    cmd.step = 1'b1;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

// ===== design/bia_datapath.sv =====
// bitmap store, free counter, registers and word scan of the allocator
module bia_datapath
    import bia_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [ACTION_W-1:0]   action,
    input  logic [INDEX_W-1:0]    slot_index,
    input  logic [COUNT_W-1:0]    count_value,
    output logic [INDEX_W-1:0]    granted_index,
    output logic                  success,
    output logic [COUNT_W-1:0]    free_count
);

    // derived sizes
    localparam int WORDS  = (MAX_SLOTS + WORD_W - 1) / WORD_W;
    localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int DEPTH  = (WORDS > 1) ? WORDS : 2;
    localparam int LW     = ($clog2(MAX_SLOTS + 1) > COUNT_W) ? $clog2(MAX_SLOTS + 1) : COUNT_W;
    localparam int CW     = LW + 1;
    localparam int CEIL_I = (MAX_SLOTS < COUNT_HW_MAX) ? MAX_SLOTS : COUNT_HW_MAX;
    localparam logic [COUNT_W-1:0] FREE_CEIL  = COUNT_W'(CEIL_I);
    localparam logic [LW-1:0]      MAX_LIMIT  = LW'(MAX_SLOTS);
    localparam logic [AW-1:0]      LAST_WORD  = AW'(WORDS - 1);

    // map memory
    logic [WORD_W-1:0] map_mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    // registers
    logic [COUNT_W-1:0] slots_reg;
    logic [INDEX_W-1:0] root_reg;
    logic [COUNT_W-1:0] free_counter_reg;
    logic [COUNT_W-1:0] free_counter_next;
    logic [AW-1:0]      word_addr_reg;
    logic [AW-1:0]      word_addr_next;
    action_t            action_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic [INDEX_W-1:0] granted_reg;
    logic [INDEX_W-1:0] granted_next;
    logic               success_reg;
    logic               op_ok;

    // scan signals
    logic [LW-1:0]         limit;
    logic [CW-1:0]         base;
    logic [CW-1:0]         base_next;
    logic [CW-1:0]         lim_ext;
    logic [CW-1:0]         avail;
    logic [WORD_W-1:0]     free_bits;
    logic [WORD_SHIFT-1:0] pos;
    logic                  found;
    logic [AW+WORD_SHIFT-1:0] found_idx;
    logic                  count_zero;
    logic                  rel_ok;
    logic                  mark_ok;
    logic [AW-1:0]         in_word;
    logic [WORD_SHIFT-1:0] bit_pos;
    logic                  bit_val;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= SLOTS_RESET;
            root_reg  <= ROOT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SLOTS_IN_USE:      slots_reg <= cfg_data;
                CFG_RESERVED_ROOT_IDX: root_reg  <= cfg_data[INDEX_W-1:0];
                default:               ;
            endcase
        end
    end

    // slot limit and range checks
    assign limit      = (LW'(slots_reg) < MAX_LIMIT) ? LW'(slots_reg) : MAX_LIMIT;
    assign count_zero = (free_counter_reg == '0);
    assign rel_ok     = (idx_reg != '0) && (LW'(idx_reg) < limit) && (idx_reg != root_reg);
    assign mark_ok    = (LW'(idx_reg) < MAX_LIMIT);
    assign in_word    = AW'(slot_index >> WORD_SHIFT);

    // free bits of the current word that lie below the limit
    assign base      = CW'({word_addr_reg, {WORD_SHIFT{1'b0}}});
    assign base_next = base + CW'(WORD_W);
    assign lim_ext   = CW'(limit);
    assign avail     = (lim_ext > base) ? (lim_ext - base) : '0;

    always_comb
    begin
        for (int j = 0; j < WORD_W; j++)
        begin
            free_bits[j] = ~rd_data_reg[j] && (avail > CW'(j));
        end
    end

    // lowest free bit
    always_comb
    begin
        pos = '0;
        for (int j = WORD_W - 1; j >= 0; j--)
        begin
            if (free_bits[j])
            begin
                pos = WORD_SHIFT'(j);
            end
        end
    end

    assign found     = |free_bits;
    assign found_idx = {word_addr_reg, pos};

    // scan continues while an allocation has no free bit yet, the free counter is not zero and words remain
    assign status.need_more  = (action_reg == ACT_ALLOCATE) && !count_zero && !found
                               && (base_next < lim_ext);
    assign status.clear_last = (word_addr_reg == LAST_WORD);

    // outcome of the action at the end of the check
    always_comb
    begin
        op_ok             = 1'b0;
        granted_next      = '0;
        free_counter_next = free_counter_reg;
        bit_pos           = idx_reg[WORD_SHIFT-1:0];
        bit_val           = 1'b1;
        unique case (action_reg)
            ACT_ALLOCATE:
            begin
                bit_pos = pos;
                op_ok   = !count_zero && found && (found_idx != '0);
                if (op_ok)
                begin
                    granted_next      = INDEX_W'(found_idx);
                    free_counter_next = free_counter_reg - COUNT_W'(1);
                end
            end
            ACT_RELEASE:
            begin
                bit_val = 1'b0;
                op_ok   = rel_ok;
                if (op_ok && (free_counter_reg < FREE_CEIL))
                begin
                    free_counter_next = free_counter_reg + COUNT_W'(1);
                end
            end
            ACT_MARK_USED:
            begin
                op_ok = mark_ok;
            end
            ACT_SET_COUNT:
            begin
                op_ok             = 1'b1;
                free_counter_next = (cnt_reg < FREE_CEIL) ? cnt_reg : FREE_CEIL;
            end
            default:
            begin
                op_ok = 1'b0;
            end
        endcase
    end

    // memory write port: clearing sweep or read-modify-write of one bit
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = word_addr_reg;
        mem_wdata = '0;
        if (cmd.clear_write)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.finish && op_ok && (action_reg != ACT_SET_COUNT))
        begin
            mem_we             = 1'b1;
            mem_wdata          = rd_data_reg;
            mem_wdata[bit_pos] = bit_val;
        end
    end

    // word address sequencing
    always_comb
    begin
        word_addr_next = word_addr_reg;
        if (cmd.clear_write)
        begin
            word_addr_next = status.clear_last ? '0 : word_addr_reg + AW'(1);
        end
        else if (cmd.load)
        begin
            word_addr_next = (action_t'(action) == ACT_ALLOCATE) ? '0 : in_word;
        end
        else if (cmd.step)
        begin
            word_addr_next = word_addr_reg + AW'(1);
        end
    end

    // map memory with registered read at the next word address
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= map_mem[word_addr_next];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_addr_reg    <= '0;
            free_counter_reg <= '0;
        end
        else
        begin
            word_addr_reg <= word_addr_next;
            if (cmd.finish)
            begin
                free_counter_reg <= free_counter_next;
            end
        end
    end

    // item and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action_t'(action);
            idx_reg    <= slot_index;
            cnt_reg    <= count_value;
        end
        if (cmd.finish)
        begin
            granted_reg <= granted_next;
            success_reg <= op_ok;
        end
    end

    assign granted_index = granted_reg;
    assign success       = success_reg;
    assign free_count    = free_counter_reg;

endmodule

// ===== design/bitmap_index_allocator.sv =====
// top level of the bitmap index allocator
// an allocation reads n map words, one 32-bit word per cycle, n from 1 up to MAX_SLOTS/32;
// release, mark-used and set-count read a single word; one item at a time, the next
// accepted at the edge that takes the result
// reset clears the counter and sweeps the map to zero, one word per cycle with busy
// high; the receiver cannot stall results
module bitmap_index_allocator
    import bia_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [ACTION_W-1:0]   action,
    input  logic [INDEX_W-1:0]    slot_index,
    input  logic [COUNT_W-1:0]    count_value,
    output logic                  done,
    output logic [INDEX_W-1:0]    granted_index,
    output logic                  success,
    output logic [COUNT_W-1:0]    free_count,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencing
    bia_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // map, counter and scan
    bia_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .action        (action),
        .slot_index    (slot_index),
        .count_value   (count_value),
        .granted_index (granted_index),
        .success       (success),
        .free_count    (free_count)
    );

endmodule

// ===== tb/sv/bia_result_checker.sv =====
// result checker for the bitmap index allocator: tracks the slot map, predicts and compares
module bia_result_checker
    import bia_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [ACTION_W-1:0]   action,
    input  logic [INDEX_W-1:0]    slot_index,
    input  logic [COUNT_W-1:0]    count_value,
    input  logic                  done,
    input  logic [INDEX_W-1:0]    granted_index,
    input  logic                  success,
    input  logic [COUNT_W-1:0]    free_count,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    outcomes_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS     = MAX_SLOTS_DEFAULT;
    localparam int FREE_CEIL = (SLOTS < COUNT_HW_MAX) ? SLOTS : COUNT_HW_MAX;

    typedef struct {
        logic [INDEX_W-1:0] granted;
        logic               ok;
        logic [COUNT_W-1:0] free;
    } outcome_t;

    // own copy of the allocator state and registers
    logic               slot_used [SLOTS];
    int unsigned        free_slots;
    logic [COUNT_W-1:0] slots_reg;
    logic [INDEX_W-1:0] root_reg;
    outcome_t           outcomes_due [$];

    initial
    begin
        fail_count       = 0;
        outcomes_pending = 0;
    end

    task automatic report_mismatch(string msg);
        $display("checker: %s at %0t ns", msg, $time);
        fail_count++;
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned seen);
        if (want != seen)
            report_mismatch($sformatf("%s expected %0d got %0d", name, want, seen));
    endtask

    function automatic int unsigned slot_limit();
        return (slots_reg < SLOTS) ? slots_reg : SLOTS;
    endfunction

    // apply one action to the tracked state and work out its result
    function automatic outcome_t apply_action(action_t act, logic [INDEX_W-1:0] idx,
                                              logic [COUNT_W-1:0] cnt);
        outcome_t    o;
        int unsigned lim;
        int unsigned i;
        lim       = slot_limit();
        o.granted = '0;
        o.ok      = 1'b0;
        case (act)
            ACT_ALLOCATE:
            begin
                // first fit below the limit; index 0 found clear means failure
                if (free_slots != 0)
                begin
                    i = 0;
                    while (i < lim && slot_used[i])
                        i++;
                    if (i != 0 && i < lim)
                    begin
                        slot_used[i] = 1'b1;
                        free_slots--;
                        o.granted = i[INDEX_W-1:0];
                        o.ok      = 1'b1;
                    end
                end
            end
            ACT_RELEASE:
            begin
                if (idx != 0 && idx < lim && idx != root_reg)
                begin
                    slot_used[idx] = 1'b0;
                    if (free_slots < FREE_CEIL)
                        free_slots++;
                    o.ok = 1'b1;
                end
            end
            ACT_MARK_USED:
            begin
                if (idx < SLOTS)
                begin
                    slot_used[idx] = 1'b1;
                    o.ok           = 1'b1;
                end
            end
            default:
            begin
                free_slots = (cnt < FREE_CEIL) ? cnt : FREE_CEIL;
                o.ok       = 1'b1;
            end
        endcase
        o.free = free_slots[COUNT_W-1:0];
        return o;
    endfunction

    // register writes, result comparison and item acceptance
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < SLOTS; k++)
                slot_used[k] = 1'b0;
            free_slots = 0;
            slots_reg  = SLOTS_RESET;
            root_reg   = ROOT_RESET;
            outcomes_due.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_SLOTS_IN_USE:      slots_reg = cfg_data;
                    CFG_RESERVED_ROOT_IDX: root_reg  = cfg_data[INDEX_W-1:0];
                    default:               ;
                endcase
            end
            if (done)
            begin
                if (outcomes_due.size() == 0)
                    report_mismatch("result with no item waiting");
                else
                begin
                    want = outcomes_due.pop_front();
                    check_field("granted_index", want.granted, granted_index);
                    check_field("success", want.ok, success);
                    check_field("free_count", want.free, free_count);
                end
            end
            if (start && !busy)
                outcomes_due.push_back(apply_action(action_t'(action), slot_index, count_value));
        end
        outcomes_pending = outcomes_due.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
// testbench top for the bitmap index allocator: clock, reset, stimulus and verdict
module tb
    import bia_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES     = 6;
    localparam int PHASE_ITEMS = 230;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    logic [ACTION_W-1:0]   action      = ACT_ALLOCATE;
    logic [INDEX_W-1:0]    slot_index  = '0;
    logic [COUNT_W-1:0]    count_value = '0;
    logic                  done;
    logic [INDEX_W-1:0]    granted_index;
    logic                  success;
    logic [COUNT_W-1:0]    free_count;
    logic                  cfg_write   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = CFG_SLOTS_IN_USE;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    int                    fail_count;
    int                    outcomes_pending;
    int unsigned           sender_gap_pct = 0;

    // slot counts and root indices visited by the random phases
    int unsigned phase_slots [PHASES] = '{40, 1024, 1, 200, 2047, 16};
    int unsigned phase_root  [PHASES] = '{1, 0, 1023, 7, 1023, 5};

    bitmap_index_allocator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .slot_index   (slot_index),
        .count_value  (count_value),
        .done         (done),
        .granted_index(granted_index),
        .success      (success),
        .free_count   (free_count),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    bia_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .slot_index      (slot_index),
        .count_value     (count_value),
        .done            (done),
        .granted_index   (granted_index),
        .success         (success),
        .free_count      (free_count),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .outcomes_pending(outcomes_pending)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // one command transfer, with an optional random gap carrying junk fields
    task automatic send_item(action_t act, logic [INDEX_W-1:0] idx, logic [COUNT_W-1:0] cnt);
        int unsigned gap;
        if ($urandom_range(99) < sender_gap_pct)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            start       <= 1'b0;
            action      <= ACTION_W'($urandom_range(3));
            slot_index  <= INDEX_W'($urandom_range(1023));
            count_value <= COUNT_W'($urandom_range(2047));
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start       <= 1'b1;
        action      <= act;
        slot_index  <= idx;
        count_value <= cnt;
        do
            @(posedge clk);
        while (busy);
    endtask

    // drop start and wait until every result is back and the block is idle
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (outcomes_pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        while (busy)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // random action, indices biased towards the managed range
    task automatic random_item(int unsigned lim);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 45)
            send_item(ACT_ALLOCATE, INDEX_W'($urandom_range(1023)),
                      COUNT_W'($urandom_range(2047)));
        else if (pick < 80)
            send_item(ACT_RELEASE,
                      INDEX_W'(($urandom_range(99) < 85) ? $urandom_range(lim)
                                                         : $urandom_range(1023)),
                      COUNT_W'($urandom_range(2047)));
        else if (pick < 90)
            send_item(ACT_MARK_USED,
                      INDEX_W'(($urandom_range(99) < 80) ? $urandom_range(lim)
                                                         : $urandom_range(1023)),
                      COUNT_W'($urandom_range(2047)));
        else
            send_item(ACT_SET_COUNT, INDEX_W'($urandom_range(1023)),
                      COUNT_W'(($urandom_range(99) < 80) ? $urandom_range(lim)
                                                         : $urandom_range(2047)));
    endtask

    initial
    begin
        int unsigned lim;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: counter empty, index 0 clear, refusals and saturation
        send_item(ACT_ALLOCATE, 10'h3FF, 11'h7FF);
        send_item(ACT_SET_COUNT, 10'h000, 11'h7FF);
        send_item(ACT_ALLOCATE, 10'h000, 11'h000);
        send_item(ACT_MARK_USED, 10'h000, 11'h555);
        send_item(ACT_ALLOCATE, 10'h2AA, 11'h2AA);
        send_item(ACT_ALLOCATE, 10'h155, 11'h555);
        send_item(ACT_RELEASE, 10'h000, 11'h000);
        send_item(ACT_RELEASE, 10'd1, 11'h000);
        send_item(ACT_RELEASE, 10'd2, 11'h7FF);
        send_item(ACT_RELEASE, 10'h3FF, 11'h000);
        send_item(ACT_RELEASE, 10'd1000, 11'h000);
        send_item(ACT_MARK_USED, 10'h3FF, 11'h000);
        send_item(ACT_SET_COUNT, 10'h3FF, 11'h000);
        send_item(ACT_ALLOCATE, 10'h000, 11'h000);
        send_item(ACT_SET_COUNT, 10'h155, 11'h2AA);

        // zero slot limit: nothing can be allocated or released
        settle();
        write_reg(CFG_SLOTS_IN_USE, 11'd0);
        write_reg(CFG_RESERVED_ROOT_IDX, 11'd1023);
        send_item(ACT_ALLOCATE, 10'h000, 11'h000);
        send_item(ACT_RELEASE, 10'd5, 11'h000);

        // tiny limit: fill it, then release the old root
        settle();
        write_reg(CFG_SLOTS_IN_USE, 11'd3);
        send_item(ACT_ALLOCATE, 10'h000, 11'h000);
        send_item(ACT_ALLOCATE, 10'h000, 11'h000);
        send_item(ACT_RELEASE, 10'd1, 11'h000);

        // random phases over several register settings
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            write_reg(CFG_SLOTS_IN_USE, CFG_DATA_W'(phase_slots[p]));
            write_reg(CFG_RESERVED_ROOT_IDX, CFG_DATA_W'(phase_root[p]));
            sender_gap_pct = (p < 2) ? 32 : (p < 4) ? 66 : 0;
            lim = (phase_slots[p] < 1024) ? phase_slots[p] : 1024;
            // mount: reserve index 0 and load a plausible free count
            send_item(ACT_MARK_USED, 10'h000, COUNT_W'($urandom_range(2047)));
            send_item(ACT_SET_COUNT, INDEX_W'($urandom_range(1023)),
                      COUNT_W'($urandom_range(lim)));
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_item(lim);
        end

        // drain and let the tail pass
        @(negedge clk);
        start <= 1'b0;
        for (int n = 0; n < 5000 && outcomes_pending != 0; n++)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (outcomes_pending != 0)
            $display("tb: %0d results never arrived", outcomes_pending);
        if (fail_count == 0 && outcomes_pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // hang guard
    initial
    begin
        #20_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
